// ===== rtl/core/arsm_pkg.sv =====
// Shared types and codes for the aged ring slot manager.
`timescale 1ns / 1ps

package arsm_pkg;

    // input item
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] elapsed;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [1:0] kind;
        logic       accepted;
        logic [7:0] slot;
        logic [7:0] range_start;
        logic [8:0] range_count;
        logic       last;
    } out_item_t;

    // configuration registers as seen by the sequencer
    typedef struct packed {
        logic [8:0]  slots_in_use;
        logic [31:0] lifetime_ticks;
        logic [3:0]  reuse_delay_frames;
    } cfg_t;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME_TICKS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REUSE_DELAY_FRAMES = 2'd2;

    localparam logic [8:0]  RST_SLOTS_IN_USE       = 9'd256;
    localparam logic [31:0] RST_LIFETIME_TICKS     = 32'd1000;
    localparam logic [3:0]  RST_REUSE_DELAY_FRAMES = 4'd3;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_FRAME = 2'd2;

    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_DRAW = 2'd2;

endpackage

// ===== rtl/core/arsm_cfg_regs.sv =====
// Configuration register bank of the aged ring slot manager.
`timescale 1ns / 1ps

module arsm_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [arsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output arsm_pkg::cfg_t                 cfg
);
    import arsm_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slots_in_use       <= RST_SLOTS_IN_USE;
            cfg_reg.lifetime_ticks     <= RST_LIFETIME_TICKS;
            cfg_reg.reuse_delay_frames <= RST_REUSE_DELAY_FRAMES;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SLOTS_IN_USE:       cfg_reg.slots_in_use       <= cfg_data[8:0];
                CFG_LIFETIME_TICKS:     cfg_reg.lifetime_ticks     <= cfg_data;
                CFG_REUSE_DELAY_FRAMES: cfg_reg.reuse_delay_frames <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/arsm_stamp_mem.sv =====
// Slot stamp memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module arsm_stamp_mem #(
    parameter int MAX_SLOTS = 256
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(MAX_SLOTS)-1:0] waddr,
    input  logic [31:0]                  wdata,
    input  logic                         re,
    input  logic [$clog2(MAX_SLOTS)-1:0] raddr,
    output logic [31:0]                  rdata
);
    logic [31:0] mem [MAX_SLOTS];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/arsm_seq.sv =====
// Sequencer: ring pointers, time and frame counters, ring walk and result register.
`timescale 1ns / 1ps

module arsm_seq #(
    parameter int MAX_SLOTS = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  arsm_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  arsm_pkg::in_item_t           in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output arsm_pkg::out_item_t          out_data,
    output logic                         mem_we,
    output logic [$clog2(MAX_SLOTS)-1:0] mem_waddr,
    output logic [31:0]                  mem_wdata,
    output logic                         mem_re,
    output logic [$clog2(MAX_SLOTS)-1:0] mem_raddr,
    input  logic [31:0]                  mem_rdata
);
    import arsm_pkg::*;

    localparam int PTR_W = $clog2(MAX_SLOTS);
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH0,
        ST_PUSH1,
        ST_ACT_RD,
        ST_ACT_CHK,
        ST_RET_RD,
        ST_RET_CHK,
        ST_TICK_END
    } state_t;

    state_t           state_reg;
    logic [PTR_W-1:0] free_ptr_reg;
    logic [PTR_W-1:0] new_ptr_reg;
    logic [PTR_W-1:0] active_ptr_reg;
    logic [PTR_W-1:0] retired_ptr_reg;
    logic [31:0]      now_reg;
    logic [31:0]      frame_reg;
    logic [CNT_W-1:0] step_reg;
    out_item_t        pend0_reg;
    out_item_t        pend1_reg;
    out_item_t        out_reg;
    logic             out_valid_reg;

    logic [31:0]      size_raw;
    logic [CNT_W-1:0] ring_n;
    logic [PTR_W-1:0] free_adv;
    logic [PTR_W-1:0] act_adv;
    logic [PTR_W-1:0] ret_adv;
    logic             add_full;
    logic             accept;
    logic             out_load;
    logic             steps_done;
    logic [31:0]      age_ticks;
    logic [31:0]      age_frames;
    logic             act_old;
    logic             ret_old;
    logic [CNT_W-1:0] act_c;
    logic [CNT_W-1:0] free_c;
    logic [CNT_W-1:0] first_cnt;
    out_item_t        add_res;
    out_item_t        tick_res;
    out_item_t        frame0;
    out_item_t        frame1;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] p1;
        p1 = CNT_W'(p) + CNT_W'(1);
        return (p1 >= n) ? '0 : PTR_W'(p1);
    endfunction

    // effective ring size, clamped to [2, MAX_SLOTS]
    always_comb
    begin
        size_raw = 32'(cfg.slots_in_use);
        if (size_raw < 32'd2)
        begin
            size_raw = 32'd2;
        end
        else if (size_raw > 32'(MAX_SLOTS))
        begin
            size_raw = 32'(MAX_SLOTS);
        end
        ring_n = CNT_W'(size_raw);
    end

    assign free_adv   = advance(free_ptr_reg, ring_n);
    assign act_adv    = advance(active_ptr_reg, ring_n);
    assign ret_adv    = advance(retired_ptr_reg, ring_n);
    assign add_full   = (free_adv == retired_ptr_reg);
    assign in_stall   = (state_reg != ST_IDLE);
    assign accept     = in_valid && !in_stall;
    assign out_load   = !out_valid_reg || !out_stall;
    assign steps_done = (step_reg == ring_n);

    assign age_ticks  = now_reg - mem_rdata;
    assign age_frames = frame_reg - mem_rdata;
    assign act_old    = (age_ticks >= cfg.lifetime_ticks);
    assign ret_old    = (age_frames >= 32'(cfg.reuse_delay_frames));

    // stamp port: add writes the time, retiring writes the frame count
    always_comb
    begin
        mem_we = ((state_reg == ST_IDLE) && accept && (in_data.op == OP_ADD) && !add_full)
              || ((state_reg == ST_ACT_CHK) && act_old);
        mem_waddr = (state_reg == ST_ACT_CHK) ? active_ptr_reg : free_ptr_reg;
        mem_wdata = (state_reg == ST_ACT_CHK) ? frame_reg : now_reg;
        mem_re = ((state_reg == ST_ACT_RD) && !steps_done && (active_ptr_reg != new_ptr_reg))
              || ((state_reg == ST_RET_RD) && !steps_done && (retired_ptr_reg != active_ptr_reg));
        mem_raddr = (state_reg == ST_ACT_RD) ? active_ptr_reg : retired_ptr_reg;
    end

    always_comb
    begin
        add_res      = '0;
        add_res.kind = KIND_ADD;
        add_res.last = 1'b1;
        if (!add_full)
        begin
            add_res.accepted = 1'b1;
            add_res.slot     = 8'(free_ptr_reg);
        end
        tick_res      = '0;
        tick_res.kind = KIND_TICK;
        tick_res.last = 1'b1;
    end

    // draw ranges; the second one starts at slot 0 when the active region wraps
    always_comb
    begin
        act_c     = CNT_W'(active_ptr_reg);
        free_c    = CNT_W'(free_ptr_reg);
        first_cnt = (act_c < ring_n) ? ring_n - act_c : '0;
        frame0      = '0;
        frame1      = '0;
        frame0.kind = KIND_DRAW;
        frame0.last = 1'b1;
        frame1.kind = KIND_DRAW;
        frame1.last = 1'b1;
        if (active_ptr_reg == free_ptr_reg)
        begin
            frame0.range_count = '0;
        end
        else if (active_ptr_reg < free_ptr_reg)
        begin
            frame0.range_start = 8'(active_ptr_reg);
            frame0.range_count = 9'(free_c - act_c);
        end
        else
        begin
            frame0.range_start = 8'(active_ptr_reg);
            frame0.range_count = 9'(first_cnt);
            if (free_ptr_reg != '0)
            begin
                frame0.last        = 1'b0;
                frame1.range_count = 9'(free_c);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            free_ptr_reg    <= '0;
            new_ptr_reg     <= '0;
            active_ptr_reg  <= '0;
            retired_ptr_reg <= '0;
            now_reg         <= '0;
            frame_reg       <= '0;
            step_reg        <= '0;
            pend0_reg       <= '0;
            pend1_reg       <= '0;
            out_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // the push states reload the result register themselves
            if (out_valid_reg && !out_stall && (state_reg != ST_PUSH0)
                && (state_reg != ST_PUSH1))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (in_data.op)
                            OP_ADD:
                            begin
                                pend0_reg <= add_res;
                                if (!add_full)
                                begin
                                    free_ptr_reg <= free_adv;
                                end
                                state_reg <= ST_PUSH0;
                            end
                            OP_TICK:
                            begin
                                now_reg   <= now_reg + 32'(in_data.elapsed);
                                step_reg  <= '0;
                                state_reg <= ST_ACT_RD;
                            end
                            OP_FRAME:
                            begin
                                new_ptr_reg <= free_ptr_reg;
                                frame_reg   <= frame_reg + 32'd1;
                                pend0_reg   <= frame0;
                                pend1_reg   <= frame1;
                                state_reg   <= ST_PUSH0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_PUSH0:
                begin
                    if (out_load)
                    begin
                        out_reg       <= pend0_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= pend0_reg.last ? ST_IDLE : ST_PUSH1;
                    end
                end
                ST_PUSH1:
                begin
                    if (out_load)
                    begin
                        out_reg       <= pend1_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_ACT_RD:
                begin
                    if (steps_done || (active_ptr_reg == new_ptr_reg))
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_RET_RD;
                    end
                    else
                    begin
                        state_reg <= ST_ACT_CHK;
                    end
                end
                ST_ACT_CHK:
                begin
                    // stamp was rewritten with the frame count on this edge
                    if (act_old)
                    begin
                        active_ptr_reg <= act_adv;
                        step_reg       <= step_reg + CNT_W'(1);
                        state_reg      <= ST_ACT_RD;
                    end
                    else
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_RET_RD;
                    end
                end
                ST_RET_RD:
                begin
                    if (steps_done || (retired_ptr_reg == active_ptr_reg))
                    begin
                        state_reg <= ST_TICK_END;
                    end
                    else
                    begin
                        state_reg <= ST_RET_CHK;
                    end
                end
                ST_RET_CHK:
                begin
                    if (ret_old)
                    begin
                        retired_ptr_reg <= ret_adv;
                        step_reg        <= step_reg + CNT_W'(1);
                        state_reg       <= ST_RET_RD;
                    end
                    else
                    begin
                        state_reg <= ST_TICK_END;
                    end
                end
                ST_TICK_END:
                begin
                    if (active_ptr_reg == free_ptr_reg)
                    begin
                        now_reg <= '0;
                    end
                    if (retired_ptr_reg == active_ptr_reg)
                    begin
                        frame_reg <= '0;
                    end
                    pend0_reg <= tick_res;
                    state_reg <= ST_PUSH0;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/core/aged_ring_slot_manager_unit.sv =====
// Top level of the aged ring slot manager.
//
//   channel | direction | handshake           | item
//   --------+-----------+---------------------+------------------------------
//   in      | in        | in_valid / in_stall | in_data: op, elapsed
//   out     | out       | out_valid/out_stall | out_data: kind..last
//   cfg     | in        | cfg_we              | cfg_index, cfg_data
//
// One item at a time. Add: accept, then load the result register.
// Frame: accept, then load the result register, once more when it draws two ranges.
// Tick: one walk retires the slots that have aged out, a second frees retired slots
// past their reuse delay, each stopping at a slot still too young; each walk step is
// a stamp memory read followed by a compare on the single read port.
// No clearing pass after reset; stamps are valid once written by an add.
// A stalled result holds the block in its push state until taken.
`timescale 1ns / 1ps

module aged_ring_slot_manager_unit #(
    parameter int MAX_SLOTS = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  arsm_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output arsm_pkg::out_item_t            out_data,
    input  logic                           cfg_we,
    input  logic [arsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);
    import arsm_pkg::*;

    localparam int PTR_W = $clog2(MAX_SLOTS);

    cfg_t             cfg;
    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    logic [31:0]      mem_wdata;
    logic             mem_re;
    logic [PTR_W-1:0] mem_raddr;
    logic [31:0]      mem_rdata;

    arsm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    arsm_stamp_mem #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    arsm_seq #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule

// ===== rtl/core/arsm_checker.sv =====
// Port-level checks of the aged ring slot manager, bound to the top level.
`timescale 1ns / 1ps

module arsm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input arsm_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input arsm_pkg::out_item_t out_data
);
    import arsm_pkg::*;

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // any known op keeps the block busy the cycle after it is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && ((in_data.op == OP_ADD) || (in_data.op == OP_TICK)
                                  || (in_data.op == OP_FRAME)) |=> in_stall)
        else $error("input taken while previous item in progress");

    a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.kind == KIND_ADD) || (out_data.kind == KIND_TICK)
                   || (out_data.kind == KIND_DRAW))
        else $error("unknown result kind");

    // add and tick replies are single results with no range
    a_single_reply: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind != KIND_DRAW)
        |-> out_data.last && (out_data.range_count == 9'd0) && (out_data.range_start == 8'd0))
        else $error("malformed add or tick reply");

    a_refused_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == KIND_ADD) && !out_data.accepted |-> out_data.slot == 8'd0)
        else $error("refused add carries a slot");

endmodule

bind aged_ring_slot_manager_unit arsm_checker u_arsm_checker (.*);

// ===== tb/arsm_result_checker.sv =====
// Checker for the aged ring slot manager: predicts each result and compares it.
`timescale 1ns / 1ps

module arsm_result_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  arsm_pkg::in_item_t             in_data,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  arsm_pkg::out_item_t            out_data,
    input  logic                           cfg_we,
    input  logic [arsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output int                             mismatches,
    output int                             outstanding,
    output int                             results_seen,
    output int                             refusals,
    output int                             split_frames
);
    import arsm_pkg::*;

    // shadow registers
    logic [8:0]  ring_cfg;
    logic [31:0] life_cfg;
    logic [3:0]  delay_cfg;

    // shadow ring state
    logic [31:0] stamp_mem [256];
    logic [7:0]  free_p;
    logic [7:0]  new_p;
    logic [7:0]  act_p;
    logic [7:0]  ret_p;
    logic [31:0] now_t;
    logic [31:0] frame_n;

    out_item_t due_results[$];

    int bad_cnt   = 0;
    int seen_cnt  = 0;
    int full_cnt  = 0;
    int split_cnt = 0;

    // effective ring size, clamped to [2, 256]
    function automatic logic [8:0] ring_len();
        if (ring_cfg < 9'd2)
            return 9'd2;
        if (ring_cfg > 9'd256)
            return 9'd256;
        return ring_cfg;
    endfunction

    // a pointer at or past the last slot wraps to 0
    function automatic logic [7:0] next_slot(logic [7:0] p, logic [8:0] n);
        return (({1'b0, p} + 9'd1) >= n) ? 8'd0 : p + 8'd1;
    endfunction

    function automatic out_item_t make_result(logic [1:0] k, logic acc, logic [7:0] s,
                                              logic [7:0] st, logic [8:0] c, logic lst);
        out_item_t r;
        r.kind        = k;
        r.accepted    = acc;
        r.slot        = s;
        r.range_start = st;
        r.range_count = c;
        r.last        = lst;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [8:0] n;
        logic [8:0] first;
        out_item_t  got;
        out_item_t  want;
        int         k;
        if (!rst_n)
        begin
            ring_cfg  = RST_SLOTS_IN_USE;
            life_cfg  = RST_LIFETIME_TICKS;
            delay_cfg = RST_REUSE_DELAY_FRAMES;
            free_p    = '0;
            new_p     = '0;
            act_p     = '0;
            ret_p     = '0;
            now_t     = '0;
            frame_n   = '0;
            foreach (stamp_mem[i])
                stamp_mem[i] = '0;
            due_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SLOTS_IN_USE:       ring_cfg  = cfg_data[8:0];
                    CFG_LIFETIME_TICKS:     life_cfg  = cfg_data;
                    CFG_REUSE_DELAY_FRAMES: delay_cfg = cfg_data[3:0];
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                got = out_data;
                seen_cnt++;
                if (due_results.size() == 0)
                begin
                    bad_cnt++;
                    if (bad_cnt <= 10)
                        $display("[%0t] unexpected result: kind %0d acc %0d slot %0d start %0d count %0d last %0d",
                                 $time, got.kind, got.accepted, got.slot, got.range_start,
                                 got.range_count, got.last);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.kind !== want.kind || got.accepted !== want.accepted ||
                        got.slot !== want.slot || got.range_start !== want.range_start ||
                        got.range_count !== want.range_count || got.last !== want.last)
                    begin
                        bad_cnt++;
                        if (bad_cnt <= 10)
                        begin
                            $display("[%0t] result mismatch", $time);
                            $display("  expected: kind %0d acc %0d slot %0d start %0d count %0d last %0d",
                                     want.kind, want.accepted, want.slot, want.range_start,
                                     want.range_count, want.last);
                            $display("  actual:   kind %0d acc %0d slot %0d start %0d count %0d last %0d",
                                     got.kind, got.accepted, got.slot, got.range_start,
                                     got.range_count, got.last);
                        end
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                n = ring_len();
                case (in_data.op)
                    OP_ADD:
                    begin
                        if (next_slot(free_p, n) == ret_p)
                        begin
                            due_results.push_back(make_result(KIND_ADD, 1'b0, '0, '0, '0, 1'b1));
                            full_cnt++;
                        end
                        else
                        begin
                            stamp_mem[free_p] = now_t;
                            due_results.push_back(make_result(KIND_ADD, 1'b1, free_p, '0, '0, 1'b1));
                            free_p = next_slot(free_p, n);
                        end
                    end
                    OP_TICK:
                    begin
                        now_t = now_t + {16'd0, in_data.elapsed};
                        k = 0;
                        // retire walk: stop at the first slot still young enough
                        while (k < n && act_p != new_p &&
                               (now_t - stamp_mem[act_p]) >= life_cfg)
                        begin
                            stamp_mem[act_p] = frame_n;
                            act_p = next_slot(act_p, n);
                            k++;
                        end
                        k = 0;
                        while (k < n && ret_p != act_p &&
                               (frame_n - stamp_mem[ret_p]) >= {28'd0, delay_cfg})
                        begin
                            ret_p = next_slot(ret_p, n);
                            k++;
                        end
                        if (act_p == free_p)
                            now_t = '0;
                        if (ret_p == act_p)
                            frame_n = '0;
                        due_results.push_back(make_result(KIND_TICK, 1'b0, '0, '0, '0, 1'b1));
                    end
                    OP_FRAME:
                    begin
                        new_p = free_p;
                        if (act_p == free_p)
                            due_results.push_back(make_result(KIND_DRAW, 1'b0, '0, '0, '0, 1'b1));
                        else if (act_p < free_p)
                            due_results.push_back(make_result(KIND_DRAW, 1'b0, '0, act_p,
                                                              {1'b0, free_p - act_p}, 1'b1));
                        else
                        begin
                            first = ({1'b0, act_p} < n) ? n - {1'b0, act_p} : 9'd0;
                            if (free_p != 8'd0)
                            begin
                                due_results.push_back(make_result(KIND_DRAW, 1'b0, '0, act_p,
                                                                  first, 1'b0));
                                due_results.push_back(make_result(KIND_DRAW, 1'b0, '0, '0,
                                                                  {1'b0, free_p}, 1'b1));
                                split_cnt++;
                            end
                            else
                                due_results.push_back(make_result(KIND_DRAW, 1'b0, '0, act_p,
                                                                  first, 1'b1));
                        end
                        frame_n = frame_n + 32'd1;
                    end
                    default: ;  // unknown op: no result, no change
                endcase
            end
        end
        mismatches   <= bad_cnt;
        outstanding  <= due_results.size();
        results_seen <= seen_cnt;
        refusals     <= full_cnt;
        split_frames <= split_cnt;
    end

endmodule

// ===== tb/aged_ring_slot_manager_unit_tb.sv =====
// Testbench top for the aged ring slot manager: stimulus, idling and verdict.
`timescale 1ns / 1ps

module aged_ring_slot_manager_unit_tb;
    import arsm_pkg::*;

    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    int mismatches;
    int outstanding;
    int results_seen;
    int refusals;
    int split_frames;

    bit calm         = 1'b0;  // no idling on either side
    int items_sent   = 0;
    int settings_run = 0;

    aged_ring_slot_manager_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    arsm_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .refusals     (refusals),
        .split_frames (split_frames)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one item and return once it has been taken.
    task automatic send_item(input logic [1:0] op, input logic [15:0] el);
        in_item_t it;
        int       gap;
        it.op      = op;
        it.elapsed = el;
        gap        = 0;
        if (!calm && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Leaves cfg_we high so back-to-back writes never toggle it within a step.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Wait until every expected result has come, then keep idling so that a trailing
    // item that produces nothing can finish.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // Empty the ring so all four pointers meet; a size change is only safe then.
    task automatic drain_ring();
        settle();
        cfg_write(CFG_LIFETIME_TICKS, 32'd0);
        cfg_we <= 1'b0;
        send_item(OP_FRAME, 16'd0);
        send_item(OP_TICK, 16'd0);
        repeat (16) send_item(OP_FRAME, 16'd0);
        send_item(OP_TICK, 16'd0);
        settle();
    endtask

    task automatic run_phase(input logic [31:0] ring, input logic [31:0] life,
                             input logic [31:0] delay, input int quota);
        int done;
        int r;
        int burst;
        int pick;
        logic [15:0] span;
        drain_ring();
        cfg_write(CFG_SLOTS_IN_USE, ring);
        cfg_write(CFG_LIFETIME_TICKS, life);
        cfg_write(CFG_REUSE_DELAY_FRAMES, delay);
        cfg_we <= 1'b0;
        settings_run++;
        done = 0;
        while (done < quota)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                send_item(OP_UNKNOWN, 16'($urandom));  // noise, not counted
            else if (r < 50)
            begin
                burst = $urandom_range(1, 6);
                repeat (burst) send_item(OP_ADD, 16'($urandom));
                done += burst;
            end
            else if (r < 72)
            begin
                send_item(OP_FRAME, 16'($urandom));
                done++;
            end
            else
            begin
                // mostly short steps so slots age across several ticks
                pick = $urandom_range(0, 19);
                if (pick < 12)
                    span = 16'($urandom_range(0, 31));
                else if (pick < 17)
                    span = 16'($urandom_range(0, 1023));
                else
                    span = 16'($urandom);
                send_item(OP_TICK, span);
                done++;
            end
        end
    endtask

    // Output side: random stall bursts, and one long hold to back the block up.
    initial
    begin : result_sink
        int stall_left;
        int taken;
        bit held;
        stall_left = 0;
        taken      = 0;
        held       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                taken++;
            if (stall_left > 0)
                stall_left--;
            else if (!held && !calm && taken >= 150 && in_valid)
            begin
                held       = 1'b1;
                stall_left = 300;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 4);
            out_stall <= (stall_left > 0);
        end
    end

    initial
    begin : stimulus
        int guard;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cfg_write(CFG_SLOTS_IN_USE, 32'd4);
        cfg_write(CFG_LIFETIME_TICKS, 32'd10);
        cfg_write(CFG_REUSE_DELAY_FRAMES, 32'd1);
        cfg_we <= 1'b0;
        settings_run++;

        // directed: empty draw, full ring, aging out, reuse, wrapped draw
        send_item(OP_FRAME, 16'd0);
        repeat (3) send_item(OP_ADD, 16'hFFFF);
        send_item(OP_ADD, 16'd0);
        send_item(OP_FRAME, 16'd0);
        send_item(OP_TICK, 16'hFFFF);
        send_item(OP_FRAME, 16'd0);
        send_item(OP_TICK, 16'd0);
        repeat (4) send_item(OP_ADD, 16'd0);
        send_item(OP_FRAME, 16'd0);
        send_item(OP_UNKNOWN, 16'hFFFF);
        send_item(OP_TICK, 16'd0);
        send_item(OP_TICK, 16'd10);
        send_item(OP_FRAME, 16'd0);
        send_item(OP_TICK, 16'd0);

        run_phase(32'd3, 32'd50, 32'd1, 40);
        run_phase(32'd1, 32'd0, 32'hFFFF_FFF0, 40);   // size clamps up, zero delay
        run_phase(32'd0, 32'd20, 32'd2, 40);
        run_phase(32'd8, 32'd200, 32'd15, 50);
        run_phase(32'h1FF, 32'd5000, 32'd3, 35);      // size clamps down to the full ring
        run_phase(32'd256, 32'hFFFF_FFFF, 32'd4, 35);
        run_phase($urandom_range(2, 12), $urandom_range(0, 300), $urandom_range(0, 15), 50);
        calm = 1'b1;
        run_phase(32'd16, 32'd100, 32'd1, 40);

        in_valid <= 1'b0;
        guard = 0;
        @(posedge clk);
        while (outstanding != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (32) @(posedge clk);

        $display("Sent %0d items over %0d register settings, %0d results compared",
                 items_sent, settings_run, results_seen);
        $display("%0d adds hit a full ring, %0d frames drew two ranges, %0d results left over",
                 refusals, split_frames, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : watchdog
        #40_000_000;
        $display("Run timed out");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
